// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the clk/rst domain.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/nscf_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checksum filter package
// Character codes, field widths, status codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package nscf_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned TAG_W    = 40;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;

  localparam logic [TAG_W-1:0]  TAG_RESET     = 40'h4750524D43;  // "GPRMC"
  localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAG_CHARS  = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_WRONG_TAG = 2'd1,
    ST_MISMATCH  = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_BODY = 4'b0010,
    PH_HEX1 = 4'b0100,
    PH_HEX2 = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // Decodes one ASCII hex digit; anything else reads as zero and not ok.
  function automatic hex_digit_t hex_decode(input logic [BYTE_W-1:0] c);
    hex_digit_t d;
    d.ok    = 1'b1;
    d.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d.value = c[3:0] + 4'd9;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/nmea_sentence_checksum_filter_top.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checksum filter
// Checks tag, checksum and length of NMEA 0183 sentences in a byte stream.
// ----------------------------------------------------------------------------
// Received characters enter one per transaction on the slave stream, and the
// block takes one every clock cycle as long as the result register is free or
// is being emptied in the same cycle. A '$' opens a sentence and restarts any
// sentence in progress. The five characters after '$' are compared with the
// tag_chars register (first character in the top byte, "GPRMC" after reset),
// and every byte strictly between '$' and '*' is XORed into the running
// checksum. The two characters after '*' are decoded as a hex checksum in
// either case; a character that is not a hex digit counts as a mismatch.
// One result transaction follows the second checksum digit: status 0 for an
// accepted sentence, 1 for a wrong tag (this wins over a checksum error), 2
// for a checksum mismatch, together with both checksums and the length from
// '$' through the last digit. A sentence that would grow past max_length is
// dropped with status 3, the checksum so far, a received sum of zero and the
// length including the offending byte, saturated at 255. Bytes outside a
// sentence and '$' itself produce nothing. Each byte is handled by the
// sentence state machine, and its result sits in the output register in the
// cycle after the byte's transaction; the only stall comes from a result
// that the master side has not yet taken. Configuration writes take effect
// at the next clock edge and are meant to be made while no result is owed.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_filter_top (
  input  logic                         clk,
  input  logic                         rst,
  // Slave stream: tdata = rx_byte[7:0].
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [nscf_pkg::BYTE_W-1:0]  s_tdata,
  // Master stream: tdata = status[1:0], computed_sum[9:2], received_sum[17:10],
  // sentence_length[25:18], zero[31:26].
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [nscf_pkg::OUT_W-1:0]   m_tdata,
  // Configuration write port.
  input  logic                         cfg_we,
  input  logic [nscf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nscf_pkg::TAG_W-1:0]   cfg_data
);
  import nscf_pkg::*;

  // Configuration registers.
  logic [TAG_W-1:0]  tag_chars;
  logic [BYTE_W-1:0] max_length;

  // Sentence state.
  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] running_xor, running_xor_next;
  logic [BYTE_W-1:0] byte_count, byte_count_next;
  logic              tag_match, tag_match_next;
  logic [3:0]        high_nibble, high_nibble_next;
  logic              hex_bad, hex_bad_next;

  // Result register.
  status_t           status;
  logic [BYTE_W-1:0] computed_sum;
  logic [BYTE_W-1:0] received_sum;
  logic [BYTE_W-1:0] sentence_length;

  // Per-byte combinational values.
  logic              accept;
  logic [BYTE_W:0]   count;
  logic              in_window;
  logic [BYTE_W-1:0] want;
  logic              tag_now;
  hex_digit_t        digit;
  logic              res_load;
  status_t           res_status;
  logic [BYTE_W-1:0] res_received;
  logic [BYTE_W-1:0] res_length;

  // The input side stalls only while an untaken result blocks the register.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign count = {1'b0, byte_count} + 9'd1;
  assign digit = hex_decode(s_tdata);

  // Tag window: sentence positions two through six, '$' being position one.
  always_comb begin
    in_window = 1'b1;
    case (count[2:0])
      3'd2:    want = tag_chars[39:32];
      3'd3:    want = tag_chars[31:24];
      3'd4:    want = tag_chars[23:16];
      3'd5:    want = tag_chars[15:8];
      3'd6:    want = tag_chars[7:0];
      default: begin
        want      = '0;
        in_window = 1'b0;
      end
    endcase
    if (count[BYTE_W:3] != '0) begin
      in_window = 1'b0;
    end
  end

  assign tag_now = tag_match && (!in_window || want == s_tdata);

  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    byte_count_next  = byte_count;
    tag_match_next   = tag_match;
    high_nibble_next = high_nibble;
    hex_bad_next     = hex_bad;
    res_load         = 1'b0;
    res_status       = ST_ACCEPTED;
    res_received     = '0;
    res_length       = count[BYTE_W-1:0];

    if (accept) begin
      if (s_tdata == CHAR_DOLLAR) begin
        phase_next       = PH_BODY;
        running_xor_next = '0;
        byte_count_next  = 8'd1;
        tag_match_next   = 1'b1;
        high_nibble_next = '0;
        hex_bad_next     = 1'b0;
      end else if (phase != PH_IDLE) begin
        if (count > {1'b0, max_length}) begin
          // Too long: report and drop, length saturated to the field width.
          res_load   = 1'b1;
          res_status = ST_TOO_LONG;
          res_length = count[BYTE_W] ? 8'hFF : count[BYTE_W-1:0];
          phase_next = PH_IDLE;
        end else begin
          byte_count_next = count[BYTE_W-1:0];
          tag_match_next  = tag_now;
          case (phase)
            PH_BODY: begin
              if (s_tdata == CHAR_STAR) begin
                phase_next = PH_HEX1;
              end else begin
                running_xor_next = running_xor ^ s_tdata;
              end
            end
            PH_HEX1: begin
              high_nibble_next = digit.value;
              hex_bad_next     = hex_bad || !digit.ok;
              phase_next       = PH_HEX2;
            end
            PH_HEX2: begin
              hex_bad_next = hex_bad || !digit.ok;
              res_load     = 1'b1;
              res_received = {high_nibble, digit.value};
              if (!tag_now) begin
                res_status = ST_WRONG_TAG;
              end else if (hex_bad_next || res_received != running_xor) begin
                res_status = ST_MISMATCH;
              end else begin
                res_status = ST_ACCEPTED;
              end
              phase_next = PH_IDLE;
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_chars   <= TAG_RESET;
      max_length  <= MAX_LEN_RESET;
      phase       <= PH_IDLE;
      running_xor <= '0;
      byte_count  <= '0;
      tag_match   <= 1'b1;
      high_nibble <= '0;
      hex_bad     <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TAG_CHARS:  tag_chars  <= cfg_data;
          REG_MAX_LENGTH: max_length <= cfg_data[BYTE_W-1:0];
          default: ;
        endcase
      end
      phase       <= phase_next;
      running_xor <= running_xor_next;
      byte_count  <= byte_count_next;
      tag_match   <= tag_match_next;
      high_nibble <= high_nibble_next;
      hex_bad     <= hex_bad_next;
      if (s_tready) begin
        m_tvalid <= res_load;
      end
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk) begin
    if (res_load) begin
      status          <= res_status;
      computed_sum    <= running_xor;
      received_sum    <= res_received;
      sentence_length <= res_length;
    end
  end

  assign m_tdata = {6'd0, sentence_length, received_sum, computed_sum, status};

  `include "assert_macros.svh"

  // An accepted sentence must carry matching checksums.
  `ASSERT_CLK_RST(a_accepted_sums_match,
    m_tvalid && status == ST_ACCEPTED |-> computed_sum == received_sum,
    "accepted result with differing checksums")

  // A dropped sentence never reports a decoded checksum.
  `ASSERT_CLK_RST(a_too_long_no_rx_sum,
    m_tvalid && status == ST_TOO_LONG |-> received_sum == '0,
    "too-long result with nonzero received checksum")

  // A dollar always opens a fresh sentence at position one.
  `ASSERT_CLK_RST(a_dollar_restarts,
    accept && s_tdata == CHAR_DOLLAR |=> phase == PH_BODY && byte_count == 8'd1,
    "dollar did not restart the sentence")

  // Outside a sentence, other bytes leave the block idle and give no result.
  `ASSERT_CLK_RST(a_idle_ignores,
    accept && phase == PH_IDLE && s_tdata != CHAR_DOLLAR |=> phase == PH_IDLE && !m_tvalid,
    "byte outside a sentence changed state or produced a result")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NMEA sentence checksum filter testbench
// Sends byte streams that carry whole, broken and oversized sentences through
// the slave stream. It predicts each verdict from a cycle-free model of the
// sentence parser and compares every result transaction field by field. It
// does this under several register settings and several idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import nscf_pkg::*;

  // A quiet stretch is at most one sender gap plus one receiver stall plus
  // the short pause before a register write.
  localparam int WATCHDOG_LIMIT = 200;
  localparam int MAX_GAP        = 16;
  localparam int REPORT_LIMIT   = 10;
  // A cut this large sends the whole frame.
  localparam int WHOLE          = 1 << 16;

  // How the two checksum digits of a generated sentence are formed.
  typedef enum int {
    SUM_UPPER,
    SUM_LOWER,
    SUM_WRONG,
    SUM_BAD_HIGH,
    SUM_BAD_LOW
  } sum_mode_t;

  // One expected result transaction.
  typedef struct packed {
    status_t    status;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic [7:0] length;
  } verdict_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [BYTE_W-1:0]    s_tdata;    // rx_byte[7:0]
  logic                 m_tvalid;
  logic                 m_tready;
  // status[1:0], computed_sum[9:2], received_sum[17:10],
  // sentence_length[25:18], zero[31:26]
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TAG_W-1:0]     cfg_data;

  // Verdicts owed by the block, oldest first.
  verdict_t owed_verdicts[$];

  int mismatch_count = 0;
  int sentence_bytes = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_run      = 0;
  int quiet_cycles   = 0;

  // Model of the sentence parser: its registers and its state.
  logic [TAG_W-1:0] model_tag;
  logic [7:0]       model_max_len;
  phase_t           sen_phase;
  logic [7:0]       sen_xor;
  logic [7:0]       sen_len;
  logic             sen_tag_ok;
  logic [3:0]       sen_high;
  logic             sen_hex_bad;

  nmea_sentence_checksum_filter_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Returns {valid, value} for an ASCII hex digit in either case.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return "0" + v;
    return (lower ? "a" : "A") + v - 8'd10;
  endfunction

  function automatic void reset_model();
    model_tag     = TAG_RESET;
    model_max_len = MAX_LEN_RESET;
    sen_phase     = PH_IDLE;
    sen_xor       = 8'h00;
    sen_len       = 8'h00;
    sen_tag_ok    = 1'b1;
    sen_high      = 4'h0;
    sen_hex_bad   = 1'b0;
  endfunction

  // Advances the parser model by one received byte. If the byte closes a
  // sentence, it queues the verdict for that sentence.
  function automatic void predict_byte(input logic [7:0] b);
    logic [8:0] next_len;
    logic [4:0] d;
    verdict_t   r;
    // A dollar always opens a fresh sentence, even in the checksum digits.
    if (b == CHAR_DOLLAR) begin
      sen_phase   = PH_BODY;
      sen_xor     = 8'h00;
      sen_len     = 8'd1;
      sen_tag_ok  = 1'b1;
      sen_high    = 4'h0;
      sen_hex_bad = 1'b0;
      return;
    end
    if (sen_phase == PH_IDLE) return;

    next_len = sen_len + 9'd1;
    if (next_len > model_max_len) begin
      r.status       = ST_TOO_LONG;
      r.computed_sum = sen_xor;
      r.received_sum = 8'h00;
      r.length       = (next_len > 9'd255) ? 8'd255 : next_len[7:0];
      owed_verdicts.push_back(r);
      sen_phase = PH_IDLE;
      return;
    end
    sen_len = next_len[7:0];

    // The tag window is positions 2 to 6. It compares whatever byte arrives
    // there, including a star or a checksum digit.
    if (next_len >= 9'd2 && next_len <= 9'd6) begin
      if (model_tag[8 * (6 - next_len) +: 8] != b) sen_tag_ok = 1'b0;
    end

    if (sen_phase == PH_BODY) begin
      if (b == CHAR_STAR) sen_phase = PH_HEX1;
      else sen_xor = sen_xor ^ b;
      return;
    end

    d = hex_digit(b);
    if (!d[4]) sen_hex_bad = 1'b1;
    if (sen_phase == PH_HEX1) begin
      sen_high  = d[3:0];
      sen_phase = PH_HEX2;
      return;
    end

    r.computed_sum = sen_xor;
    r.received_sum = {sen_high, d[3:0]};
    r.length       = next_len[7:0];
    // A wrong tag wins over a bad checksum.
    if (!sen_tag_ok) r.status = ST_WRONG_TAG;
    else if (sen_hex_bad || r.received_sum != sen_xor) r.status = ST_MISMATCH;
    else r.status = ST_ACCEPTED;
    owed_verdicts.push_back(r);
    sen_phase = PH_IDLE;
  endfunction

  // The receiver stalls at the rate of the current phase. The length of a
  // stall is capped by MAX_GAP, so the watchdog limit holds.
  always @(negedge clk) begin
    if (stall_run < MAX_GAP && $urandom_range(99) < recv_stall_pct) begin
      m_tready = 1'b0;
      stall_run++;
    end else begin
      m_tready = 1'b1;
      stall_run = 0;
    end
  end

  // Each result transaction is checked against the oldest owed verdict.
  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (owed_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result transaction: tdata %08h", m_tdata);
      end else begin
        want = owed_verdicts.pop_front();
        if (m_tdata[1:0] !== want.status || m_tdata[9:2] !== want.computed_sum ||
            m_tdata[17:10] !== want.received_sum || m_tdata[25:18] !== want.length ||
            m_tdata[31:26] !== 6'd0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $write("verdict mismatch: expected status %0d sum %02h rx %02h len %0d, ",
                   want.status, want.computed_sum, want.received_sum, want.length);
            $display("got status %0d sum %02h rx %02h len %0d pad %02h",
                     m_tdata[1:0], m_tdata[9:2], m_tdata[17:10], m_tdata[25:18],
                     m_tdata[31:26]);
          end
        end
      end
    end
  end

  // The watchdog counts cycles in which no transaction and no register
  // write takes place. Any of those resets the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sends one byte as a slave-side transaction. It is entered and left at a
  // falling edge. tvalid stays high on the way out, so back-to-back bytes
  // need no gap between them.
  task automatic send_byte(input logic [7:0] b, input bit counts);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
      gap++;
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_byte(b);
    if (counts) sentence_bytes++;
    @(negedge clk);
  endtask

  // The sender holds off until the block owes nothing more.
  task automatic hold_until_drained();
    s_tvalid = 1'b0;
    while (owed_verdicts.size() != 0) @(negedge clk);
  endtask

  // A register is written only while the block is idle. Bytes that give no
  // verdict may still be in flight when the queue empties, so the write waits
  // on a further pause before it is made.
  task automatic write_reg(input cfg_reg_t idx, input logic [TAG_W-1:0] value);
    hold_until_drained();
    repeat (3) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_TAG_CHARS) model_tag = value;
    else model_max_len = value[7:0];
  endtask

  // Builds the frame "$", tag, body, "*", two digits and sends its first
  // cut bytes. The body never holds a dollar or a star. The correct digits
  // are those a well-behaved talker would send.
  task automatic send_sentence(input logic [TAG_W-1:0] tag, input int body_len,
                               input sum_mode_t mode, input int cut);
    logic [7:0] frame[$];
    logic [7:0] c;
    logic [7:0] sum;
    logic [4:0] d;
    frame.push_back(CHAR_DOLLAR);
    for (int i = 4; i >= 0; i--) frame.push_back(tag[8 * i +: 8]);
    for (int i = 0; i < body_len; i++) begin
      do c = 8'($urandom_range(255)); while (c == CHAR_DOLLAR || c == CHAR_STAR);
      frame.push_back(c);
    end
    sum = 8'h00;
    for (int i = 1; i < frame.size(); i++) begin
      if (frame[i] == CHAR_STAR) break;
      sum ^= frame[i];
    end
    if (mode == SUM_WRONG) sum ^= 8'($urandom_range(1, 255));
    frame.push_back(CHAR_STAR);
    frame.push_back(hex_char(sum[7:4], mode == SUM_LOWER));
    frame.push_back(hex_char(sum[3:0], mode == SUM_LOWER));
    if (mode == SUM_BAD_HIGH || mode == SUM_BAD_LOW) begin
      do begin
        c = 8'($urandom_range(255));
        d = hex_digit(c);
      end while (d[4] || c == CHAR_DOLLAR);
      frame[frame.size() - ((mode == SUM_BAD_HIGH) ? 2 : 1)] = c;
    end
    for (int i = 0; i < frame.size() && i < cut; i++) send_byte(frame[i], 1'b1);
  endtask

  // The reset tag and length. Bytes outside a sentence, including both
  // extremes of the byte range, give nothing.
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_sentence(TAG_RESET, 0, SUM_UPPER, WHOLE);
  endtask

  // Every verdict of a complete sentence: lower-case digits, a wrong tag
  // together with a wrong checksum, and a non-hex digit in either place.
  task automatic test_status_codes();
    send_sentence(TAG_RESET, 3, SUM_LOWER, WHOLE);
    send_sentence(TAG_RESET ^ 40'h01, 0, SUM_WRONG, WHOLE);
    send_sentence(TAG_RESET, 1, SUM_BAD_LOW, WHOLE);
    send_sentence(TAG_RESET, 0, SUM_BAD_HIGH, WHOLE);
  endtask

  // A dollar restarts a sentence in the tag and between the two digits.
  task automatic test_restart();
    send_sentence(TAG_RESET, 2, SUM_UPPER, 4);
    send_sentence(TAG_RESET, 0, SUM_UPPER, 8);
    send_sentence(TAG_RESET, 1, SUM_UPPER, WHOLE);
  endtask

  // With "*00" at the head of the tag, "$*00" closes inside the tag window
  // and matches.
  task automatic test_tag_window();
    write_reg(REG_TAG_CHARS, {"*00", "ZZ"});
    send_byte(CHAR_DOLLAR, 1'b1);
    send_byte(CHAR_STAR, 1'b1);
    send_byte("0", 1'b1);
    send_byte("0", 1'b1);
    write_reg(REG_TAG_CHARS, TAG_RESET);
  endtask

  // The length limit is tested at the shortest full sentence and one byte
  // over it, at zero and one, and at 255, where the reported length
  // saturates.
  task automatic test_length_limits();
    write_reg(REG_MAX_LENGTH, 40'd9);
    send_sentence(TAG_RESET, 0, SUM_UPPER, WHOLE);
    send_sentence(TAG_RESET, 1, SUM_UPPER, WHOLE);
    write_reg(REG_MAX_LENGTH, 40'd1);
    send_byte(CHAR_DOLLAR, 1'b1);
    send_byte("G", 1'b1);
    write_reg(REG_MAX_LENGTH, 40'd0);
    send_byte(CHAR_DOLLAR, 1'b1);
    send_byte("A", 1'b1);
    write_reg(REG_MAX_LENGTH, 40'd255);
    send_sentence(TAG_RESET, 250, SUM_UPPER, WHOLE);
  endtask

  // Random traffic under one register setting and one idle pattern. Most
  // of it is whole sentences with random content and checksum forms. The rest
  // is oversized, cut-off, noise or a pause until the block is drained.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [TAG_W-1:0] tag, input int max_len,
                                     input int n_bytes);
    int goal;
    int pick;
    int body_cap;
    int body;
    logic [TAG_W-1:0] t;
    write_reg(REG_TAG_CHARS, tag);
    write_reg(REG_MAX_LENGTH, TAG_W'(max_len));
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    body_cap = (max_len > 9) ? max_len - 9 : 0;
    if (body_cap > 24) body_cap = 24;
    goal = sentence_bytes + n_bytes;
    while (sentence_bytes < goal) begin
      pick = $urandom_range(99);
      t    = tag;
      // About one sentence in seven carries a single flipped tag bit.
      if ($urandom_range(99) < 15) t[$urandom_range(TAG_W - 1)] ^= 1'b1;
      body = $urandom_range(body_cap);
      if (pick < 70) begin
        send_sentence(t, body, sum_mode_t'($urandom_range(4)), WHOLE);
      end else if (pick < 74) begin
        send_sentence(t, max_len - 9 + $urandom_range(1, 3), SUM_UPPER, WHOLE);
      end else if (pick < 86) begin
        send_sentence(t, body, sum_mode_t'($urandom_range(4)),
                      $urandom_range(1, body + 8));
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)) == CHAR_DOLLAR ?
                                                8'h00 : 8'($urandom_range(255)), 1'b0);
      end else begin
        hold_until_drained();
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_TAG_CHARS;
    cfg_data  = '0;
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_status_codes();
    test_restart();
    test_tag_window();
    test_length_limits();
    test_random_traffic(0, 0, TAG_RESET, MAX_LEN_RESET, 230);
    test_random_traffic(67, 0, {"GNGGA"}, 255, 230);
    test_random_traffic(0, 67, 40'h00_0000_0000, 9, 230);
    test_random_traffic(38, 38, 40'hFF_FFFF_FFFF, 40, 230);

    // Let the last results drain, then wait before the verdict so that any stray
    // transaction can show up.
    s_tvalid = 1'b0;
    while (owed_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
